// File: hdl/lsdh_pkg.sv
// Shared types and constants for the LRU stack distance histogram.
// No dependencies; imported by every module of the block.
package lsdh_pkg;

    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_KEY_BITS    = 32;

    localparam int KEY_IN_W  = 32;
    localparam int BIDX_W    = 9;
    localparam int DIST_W    = 8;
    localparam int OUTC_W    = 2;
    localparam int COUNT_W   = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // action codes
    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // outcome codes
    localparam logic [OUTC_W-1:0] OUT_HIT    = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_BEYOND = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_READ   = 2'd2;

    // broadcast to every stack cell
    typedef struct packed {
        logic compare;
        logic update;
        logic hit;
    } cell_ctrl_t;

    // request to the histogram store
    typedef struct packed {
        logic start;
        logic bump;
    } hist_req_t;

endpackage

// File: hdl/lsdh_cell.sv
// One entry of the recency stack: key, valid flag and match flag.
// Depends on lsdh_pkg.
module lsdh_cell #(
    parameter int KEY_BITS    = lsdh_pkg::DEF_KEY_BITS,
    parameter int STACK_DEPTH = lsdh_pkg::DEF_STACK_DEPTH,
    parameter int CELL_POS    = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lsdh_pkg::cell_ctrl_t             ctrl,
    input  logic [$clog2(STACK_DEPTH)-1:0]   hit_pos,
    input  logic [KEY_BITS-1:0]              search_key,
    input  logic [KEY_BITS-1:0]              prev_key,
    input  logic                             prev_valid,
    output logic [KEY_BITS-1:0]              key,
    output logic                             valid,
    output logic                             match
);
    import lsdh_pkg::*;

    localparam int POS_W = $clog2(STACK_DEPTH);

    logic [KEY_BITS-1:0] key_reg;
    logic                valid_reg;
    logic                match_reg;
    logic                shift_en;

    // a miss shifts the whole row; a hit only the cells at or above it
    assign shift_en = ctrl.update && (!ctrl.hit || (POS_W'(CELL_POS) <= hit_pos));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.compare)
            begin
                match_reg <= valid_reg && (key_reg == search_key);
            end
            if (shift_en)
            begin
                valid_reg <= prev_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg <= prev_key;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

// File: hdl/lsdh_hist.sv
// Histogram store: saturating counters in a single-port-write memory,
// with a clearing pass after reset. Depends on lsdh_pkg.
module lsdh_hist #(
    parameter int STACK_DEPTH = lsdh_pkg::DEF_STACK_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lsdh_pkg::hist_req_t                  req,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]     addr,
    output logic                                 busy,
    output logic                                 done,
    output logic [lsdh_pkg::COUNT_W-1:0]         count
);
    import lsdh_pkg::*;

    localparam int ENTRIES = STACK_DEPTH + 1;
    localparam int AW      = $clog2(ENTRIES);

    logic [COUNT_W-1:0] mem [ENTRIES];

    logic               clear_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               pend_reg;
    logic               bump_reg;
    logic [AW-1:0]      addr_reg;
    logic [COUNT_W-1:0] rdata_reg;
    logic [COUNT_W-1:0] count_next;

    assign count_next = (rdata_reg == COUNT_MAX) ? rdata_reg : rdata_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            pend_reg <= req.start && !clear_reg;
            if (clear_reg)
            begin
                if (clr_addr_reg == AW'(ENTRIES - 1))
                begin
                    clear_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rdata_reg <= mem[addr];
            addr_reg  <= addr;
            bump_reg  <= req.bump;
        end
        if (clear_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (pend_reg && bump_reg)
        begin
            mem[addr_reg] <= count_next;
        end
    end

    assign busy  = clear_reg;
    assign done  = pend_reg;
    assign count = rdata_reg;

endmodule

// File: hdl/lru_stack_distance_histogram_top.sv
// LRU stack reuse-distance histogram, top level.
// Depends on lsdh_pkg, lsdh_cell and lsdh_hist.
//
// Keeps the STACK_DEPTH most recently used keys in a row of cells, most recent
// at cell 0. An access item (tuser = 0) compares its key against every cell at
// once; a hit at position p reports distance p and bumps bucket p, a miss
// (cold or beyond the stack) bumps the beyond bucket STACK_DEPTH. The key then
// moves to the top: cells at or above the hit, or all cells on a miss, load
// from their upper neighbour, so the least recent key drops off a full stack.
// A read item (tuser = 1) returns the count of bucket_index; indices above
// STACK_DEPTH read as zero. Counters saturate at all ones. An access passes
// through input, compare, encode, shift with counter read, counter write and
// output load; a read through input with counter read, counter data and output
// load; a read past the beyond bucket goes from input straight to output load.
// One item is in flight at a time; the output register lets a new item be taken
// while a result waits. After reset the counter memory is cleared entry by
// entry, and s_axis_tready stays low until the clearing pass is done.
module lru_stack_distance_histogram_top #(
    parameter int STACK_DEPTH = lsdh_pkg::DEF_STACK_DEPTH,
    parameter int KEY_BITS    = lsdh_pkg::DEF_KEY_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // access_key[31:0], bucket_index[40:32], zero pad
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // reuse_distance[7:0], bucket_count[39:8]
    output logic [1:0]  m_axis_tuser    // outcome
);
    import lsdh_pkg::*;

    localparam int POS_W = $clog2(STACK_DEPTH);
    localparam int AW    = $clog2(STACK_DEPTH + 1);
    localparam int CW    = (AW > BIDX_W) ? AW : BIDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_ENCODE,
        ST_UPDATE,
        ST_HIST,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic                action_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                hit_reg;
    logic [OUTC_W-1:0]   res_outcome_reg;
    logic [DIST_W-1:0]   res_dist_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic                out_valid_reg;
    logic [OUTC_W-1:0]   out_outcome_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic                in_action;
    logic [KEY_IN_W-1:0] in_key;
    logic [BIDX_W-1:0]   in_bidx;
    logic                in_accept;
    logic                idx_ok;
    logic                emit_load;

    logic [KEY_BITS-1:0] cell_key   [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] cell_valid;
    logic [STACK_DEPTH-1:0] cell_match;
    cell_ctrl_t          cctrl;

    logic [POS_W-1:0]    pos_enc;
    logic                hit_enc;

    hist_req_t           hreq;
    logic [AW-1:0]       haddr;
    logic                hbusy;
    logic                hdone;
    logic [COUNT_W-1:0]  hcount;

    assign in_action = s_axis_tuser[0];
    assign in_key    = s_axis_tdata[31:0];
    assign in_bidx   = s_axis_tdata[40:32];
    assign idx_ok    = CW'(in_bidx) <= CW'(STACK_DEPTH);

    assign s_axis_tready = (state_reg == ST_IDLE) && !hbusy;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // result moves to the output register once that is free or being taken
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    // stack cells
    assign cctrl.compare = (state_reg == ST_MATCH);
    assign cctrl.update  = (state_reg == ST_UPDATE);
    assign cctrl.hit     = hit_reg;

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [KEY_BITS-1:0] up_key;
        logic                up_valid;

        if (i == 0)
        begin : g_top
            assign up_key   = key_reg;
            assign up_valid = 1'b1;
        end
        else
        begin : g_rest
            assign up_key   = cell_key[i-1];
            assign up_valid = cell_valid[i-1];
        end

        lsdh_cell #(
            .KEY_BITS    (KEY_BITS),
            .STACK_DEPTH (STACK_DEPTH),
            .CELL_POS    (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cctrl),
            .hit_pos    (pos_reg),
            .search_key (key_reg),
            .prev_key   (up_key),
            .prev_valid (up_valid),
            .key        (cell_key[i]),
            .valid      (cell_valid[i]),
            .match      (cell_match[i])
        );
    end

    // keys in the stack are distinct, so at most one match: OR-encode it
    always_comb
    begin
        pos_enc = '0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            if (cell_match[i])
            begin
                pos_enc = pos_enc | POS_W'(i);
            end
        end
    end
    assign hit_enc = |cell_match;

    // counter store requests: read on a read item, bump after the shift
    always_comb
    begin
        hreq.start = 1'b0;
        hreq.bump  = 1'b0;
        haddr      = AW'(in_bidx);
        if (state_reg == ST_UPDATE)
        begin
            hreq.start = 1'b1;
            hreq.bump  = 1'b1;
            haddr      = hit_reg ? AW'(pos_reg) : AW'(STACK_DEPTH);
        end
        else if (in_accept && (in_action == ACT_READ) && idx_ok)
        begin
            hreq.start = 1'b1;
        end
    end

    lsdh_hist #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .addr  (haddr),
        .busy  (hbusy),
        .done  (hdone),
        .count (hcount)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            action_reg      <= ACT_ACCESS;
            key_reg         <= '0;
            pos_reg         <= '0;
            hit_reg         <= 1'b0;
            res_outcome_reg <= OUT_HIT;
            res_dist_reg    <= '0;
            res_count_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_outcome_reg <= OUT_HIT;
            out_dist_reg    <= '0;
            out_count_reg   <= '0;
        end
        else
        begin
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        action_reg <= in_action;
                        key_reg    <= KEY_BITS'(in_key);
                        if (in_action == ACT_ACCESS)
                        begin
                            state_reg <= ST_MATCH;
                        end
                        else if (idx_ok)
                        begin
                            state_reg <= ST_HIST;
                        end
                        else
                        begin
                            res_outcome_reg <= OUT_READ;
                            res_dist_reg    <= '0;
                            res_count_reg   <= '0;
                            state_reg       <= ST_EMIT;
                        end
                    end
                end
                ST_MATCH:
                begin
                    state_reg <= ST_ENCODE;
                end
                ST_ENCODE:
                begin
                    pos_reg   <= pos_enc;
                    hit_reg   <= hit_enc;
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    state_reg <= ST_HIST;
                end
                ST_HIST:
                begin
                    if (hdone)
                    begin
                        if (action_reg == ACT_READ)
                        begin
                            res_outcome_reg <= OUT_READ;
                            res_dist_reg    <= '0;
                            res_count_reg   <= hcount;
                        end
                        else
                        begin
                            res_outcome_reg <= hit_reg ? OUT_HIT : OUT_BEYOND;
                            res_dist_reg    <= hit_reg ? DIST_W'(pos_reg) : '0;
                            res_count_reg   <= '0;
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        out_outcome_reg <= res_outcome_reg;
                        out_dist_reg    <= res_dist_reg;
                        out_count_reg   <= res_count_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_dist_reg};
    assign m_axis_tuser  = out_outcome_reg;

endmodule
